[src/sbc_pkg.sv]
// ----------------------------------------------------------------------------
// sbc_pkg: shared types, tables and helpers for the S-box byte cipher / MAC
// Operation codes, substitution tables, position schedule, key and padding
// helpers.
// ----------------------------------------------------------------------------
package sbc_pkg;

  typedef enum logic [1:0] {
    OP_DECRYPT   = 2'd0,
    OP_MAC_FIRST = 2'd1,
    OP_MAC_NEXT  = 2'd2,
    OP_MAC_FINAL = 2'd3
  } op_t;

  localparam logic [6:0] LAST_FULL   = 7'd127;  // 128 rounds
  localparam logic [6:0] LAST_SHORT  = 7'd39;   // 40 rounds
  localparam logic [6:0] LAST_PADDED = 7'd103;  // 104 rounds
  localparam logic [3:0] KEY_LAST_IDX = 4'd9;
  localparam logic [7:0] PAD_BASE    = 8'h61;

  localparam logic [2:0] POS_FULL [16] = '{
    3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7,
    3'd0, 3'd3, 3'd6, 3'd1, 3'd4, 3'd7, 3'd2, 3'd5
  };

  localparam logic [7:0] SUB_ODD [256] = '{
    8'hDA,8'h26,8'hE8,8'h72,8'h11,8'h52,8'h3E,8'h46,8'h32,8'hFF,8'h8C,8'h1E,8'hA7,8'hBE,8'h2C,8'h29,
    8'h5F,8'h86,8'h7E,8'h75,8'h0A,8'h08,8'hA5,8'h21,8'h61,8'hFB,8'h7A,8'h58,8'h60,8'hF7,8'h81,8'h4F,
    8'hE4,8'hFC,8'hDF,8'hB1,8'hBB,8'h6A,8'h02,8'hB3,8'h0B,8'h6E,8'h5D,8'h5C,8'hD5,8'hCF,8'hCA,8'h2A,
    8'h14,8'hB7,8'h90,8'hF3,8'hD9,8'h37,8'h3A,8'h59,8'h44,8'h69,8'hC9,8'h78,8'h30,8'h16,8'h39,8'h9A,
    8'h0D,8'h05,8'h1F,8'h8B,8'h5E,8'hEE,8'h1B,8'hC4,8'h76,8'h43,8'hBD,8'hEB,8'h42,8'hEF,8'hF9,8'hD0,
    8'h4D,8'hE3,8'hF4,8'h57,8'h56,8'hA3,8'h0F,8'hA6,8'h50,8'hFD,8'hDE,8'hD2,8'h80,8'h4C,8'hD3,8'hCB,
    8'hF8,8'h49,8'h8F,8'h22,8'h71,8'h84,8'h33,8'hE0,8'h47,8'hC2,8'h93,8'hBC,8'h7C,8'h3B,8'h9C,8'h7D,
    8'hEC,8'hC3,8'hF1,8'h89,8'hCE,8'h98,8'hA2,8'hE1,8'hC1,8'hF2,8'h27,8'h12,8'h01,8'hEA,8'hE5,8'h9B,
    8'h25,8'h87,8'h96,8'h7B,8'h34,8'h45,8'hAD,8'hD1,8'hB5,8'hDB,8'h83,8'h55,8'hB0,8'h9E,8'h19,8'hD7,
    8'h17,8'hC6,8'h35,8'hD8,8'hF0,8'hAE,8'hD4,8'h2B,8'h1D,8'hA0,8'h99,8'h8A,8'h15,8'h00,8'hAF,8'h2D,
    8'h09,8'hA8,8'hF5,8'h6C,8'hA1,8'h63,8'h67,8'h51,8'h3C,8'hB2,8'hC0,8'hED,8'h94,8'h03,8'h6F,8'hBA,
    8'h3F,8'h4E,8'h62,8'h92,8'h85,8'hDD,8'hAB,8'hFE,8'h10,8'h2E,8'h68,8'h65,8'hE7,8'h04,8'hF6,8'h0C,
    8'h20,8'h1C,8'hA9,8'h53,8'h40,8'h77,8'h2F,8'hA4,8'hFA,8'h6D,8'h73,8'h28,8'hE2,8'hCD,8'h79,8'hC8,
    8'h97,8'h66,8'h8E,8'h82,8'h74,8'h06,8'hC7,8'h88,8'h1A,8'h4A,8'h6B,8'hCC,8'h41,8'hE9,8'h9D,8'hB8,
    8'h23,8'h9F,8'h3D,8'hBF,8'h8D,8'h95,8'hC5,8'h13,8'hB9,8'h24,8'h5A,8'hDC,8'h64,8'h18,8'h38,8'h91,
    8'h7F,8'h5B,8'h70,8'h54,8'h07,8'hB6,8'h4B,8'h0E,8'h36,8'hAC,8'h31,8'hE6,8'hD6,8'h48,8'hAA,8'hB4
  };

  localparam logic [7:0] SUB_EVEN [256] = '{
    8'h8E,8'hD5,8'h32,8'h53,8'h4B,8'h18,8'h7F,8'h95,8'hBE,8'h30,8'hF3,8'hE0,8'h22,8'hE1,8'h68,8'h90,
    8'h82,8'hC8,8'hA8,8'h57,8'h21,8'hC5,8'h38,8'h73,8'h61,8'h5D,8'h5A,8'hD6,8'h60,8'hB7,8'h48,8'h70,
    8'h2B,8'h7A,8'h1D,8'hD1,8'hB1,8'hEC,8'h7C,8'hAA,8'h2F,8'h1F,8'h37,8'h58,8'h72,8'h88,8'hFF,8'h87,
    8'h1C,8'hCB,8'h00,8'hE6,8'h4E,8'hAB,8'hEB,8'hB3,8'hF7,8'h59,8'h71,8'h6A,8'h64,8'h2A,8'h55,8'h4D,
    8'hFC,8'hC0,8'h51,8'h01,8'h2D,8'hC4,8'h54,8'hE2,8'h9F,8'h26,8'h16,8'h27,8'hF2,8'h9C,8'h86,8'h11,
    8'h05,8'h29,8'hA2,8'h78,8'h49,8'hB2,8'hA6,8'hCA,8'h96,8'hE5,8'h33,8'h3F,8'h46,8'hBA,8'hD0,8'hBB,
    8'h5F,8'h84,8'h98,8'hE4,8'hF9,8'h0A,8'h62,8'hEE,8'hF6,8'hCF,8'h94,8'hF0,8'hEA,8'h1E,8'hBF,8'h07,
    8'h9B,8'hD9,8'hE9,8'h74,8'hC6,8'hA4,8'hB9,8'h56,8'h3E,8'hDB,8'hC7,8'h15,8'hE3,8'h80,8'hD7,8'hED,
    8'hEF,8'h13,8'hAC,8'hA1,8'h91,8'hC2,8'h89,8'h5B,8'h08,8'h0B,8'h4C,8'h02,8'h3A,8'h5C,8'hA9,8'h3B,
    8'hCE,8'h6B,8'hA7,8'hE7,8'hCD,8'h7B,8'hA0,8'h47,8'h09,8'h6D,8'hF8,8'hF1,8'h8B,8'hB0,8'h12,8'h42,
    8'h4A,8'h9A,8'h17,8'hB4,8'h7E,8'hAD,8'hFE,8'hFD,8'h2C,8'hD3,8'hF4,8'hB6,8'hA3,8'hFA,8'hDF,8'hB8,
    8'hD4,8'hDA,8'h0F,8'h50,8'h93,8'h66,8'h6C,8'h20,8'hD8,8'h8A,8'hDD,8'h31,8'h1A,8'h8C,8'h06,8'hD2,
    8'h44,8'hE8,8'h23,8'h43,8'h6E,8'h10,8'h69,8'h36,8'hBC,8'h19,8'h8D,8'h24,8'h81,8'h14,8'h40,8'hC9,
    8'h6F,8'h2E,8'h45,8'h52,8'h41,8'h92,8'h34,8'hFB,8'h5E,8'h0D,8'hF5,8'h76,8'h25,8'h77,8'h63,8'h65,
    8'hAF,8'h4F,8'hCC,8'h03,8'h9D,8'h0C,8'h28,8'h39,8'h85,8'hDE,8'hB5,8'h7D,8'h67,8'h83,8'hBD,8'hC3,
    8'hDC,8'h3C,8'hAE,8'h99,8'h04,8'h75,8'h8F,8'h97,8'hC1,8'hA5,8'h9E,8'h35,8'h0E,8'h3D,8'h1B,8'h79
  };

  // Rotate the 80-bit key right by one bit; byte i LSB feeds byte i+1 MSB.
  function automatic logic [79:0] key_rot(input logic [79:0] k);
    logic [79:0] r;
    r = '0;
    for (int i = 0; i < 10; i++) begin
      r[8*i +: 7] = k[8*i+1 +: 7];
      r[8*i+7]    = k[8*((i+9)%10)];
    end
    return r;
  endfunction

  function automatic logic [79:0] key_build(input logic [63:0] kb, input logic [15:0] tail,
                                            input logic ten);
    logic [7:0] k8;
    logic [7:0] k9;
    if (ten) begin
      k8 = tail[7:0];
      k9 = tail[15:8];
    end else begin
      k8 = tail[15:8] ^ kb[7:0];
      k9 = tail[7:0] ^ kb[15:8];
    end
    return {k9, k8, kb};
  endfunction

  // Bytes from the count upward become 0x61, 0x62, ...; counts above 8 act as 8.
  function automatic logic [63:0] pad_block(input logic [63:0] blk, input logic [3:0] cnt);
    logic [3:0]  n;
    logic [63:0] r;
    n = (cnt > 4'd8) ? 4'd8 : cnt;
    r = blk;
    for (int i = 0; i < 8; i++) begin
      if (4'(i) >= n) begin
        r[8*i +: 8] = PAD_BASE + 8'(4'(i) - n);
      end
    end
    return r;
  endfunction

  function automatic logic [2:0] sched_pos(input logic full, input logic [6:0] c);
    return full ? POS_FULL[c[3:0]] : c[2:0];
  endfunction

endpackage

[src/sbox_byte_cipher_with_mac.sv]
// ----------------------------------------------------------------------------
// sbox_byte_cipher_with_mac: byte-wise S-box block decrypt and chained MAC
// One round per clock over an 8-byte working block held in a small RAM.
// ----------------------------------------------------------------------------
// One item is worked on at a time; in_ready is high whenever the engine is
// idle, even while a finished result still sits in the output register.
// Steps per item, after the idle state that takes the beat: decrypt loads
// the block, primes, runs 128 rounds and reads out; mac first loads the
// padded block; mac next primes, runs 40 rounds, xors it into the chain;
// mac final primes, runs 40 (104 if padded) rounds, reads out.  A result beat
// that finds the output register still full waits in the hold state until
// it drains.  The round loop sets the rate: every round is one
// read-modify-write of the 16 x 8 block RAM (read data registered) through
// one S-box lookup.  RAM entries 0..7 hold the MAC chain, entries 8..15 are
// decrypt scratch, so a decrypt never disturbs the chain.  Per-entry valid
// bits make the chain read as zero after reset.  Results (op 0 and 3)
// appear on out_valid / out_ready; mac first/next produce no beat.
// ----------------------------------------------------------------------------
module sbox_byte_cipher_with_mac
  import sbc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  operation,
  input  logic [63:0] block,
  input  logic [3:0]  byte_count,
  input  logic [63:0] key_bytes,
  input  logic [15:0] key_tail,
  input  logic        ten_byte_key,
  input  logic [39:0] expected_signature,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] result_block,
  output logic        signature_ok
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_LOAD   = 8'b0000_0010,  // write 8 bytes into RAM
    S_PRIME0 = 8'b0000_0100,  // read first source byte
    S_PRIME1 = 8'b0000_1000,  // latch it, read first destination
    S_ROUND  = 8'b0001_0000,  // one round per cycle
    S_MIX    = 8'b0010_0000,  // xor padded block into chain
    S_READ   = 8'b0100_0000,  // gather block for result
    S_HOLD   = 8'b1000_0000   // wait for output register
  } state_t;

  state_t      state;
  logic [79:0] mac_key;
  logic        mac_padded;
  logic [15:0] vld;

  // item registers
  op_t         op;
  logic [63:0] blk;
  logic [63:0] pad;
  logic        pad_flag;
  logic [39:0] sig;
  logic        scratch;
  logic        full;
  logic [6:0]  last;
  logic [79:0] work_key;
  logic [6:0]  c;
  logic [3:0]  ki;
  logic [2:0]  j;
  logic [7:0]  cur;
  logic [63:0] rbuf;

  // block RAM and read path
  logic [7:0] mem [16];
  logic [7:0] mem_q;
  logic       rd_valid;
  logic       rd_fwd;
  logic [7:0] fwd_data;
  logic [3:0] raddr;
  logic       we;
  logic [3:0] waddr;
  logic [7:0] wdata;
  logic [7:0] rdata;

  // round datapath
  logic [79:0] kcur;
  logic [7:0]  kb;
  logic [7:0]  sx;
  logic [7:0]  sub;

  op_t op_in;
  assign op_in    = op_t'(operation);
  assign in_ready = (state == S_IDLE);

  // A write to the address being read wins over stale RAM data.
  assign rdata = rd_fwd ? fwd_data : (rd_valid ? mem_q : 8'h00);

  assign kcur = (ki == 4'd0) ? key_rot(work_key) : work_key;
  assign kb   = kcur[{ki, 3'b000} +: 8];
  assign sx   = cur ^ kb;
  assign sub  = kb[0] ? SUB_ODD[sx] : SUB_EVEN[sx];

  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    raddr = '0;
    unique case (state)
      S_LOAD: begin
        we    = 1'b1;
        waddr = {scratch, j};
        wdata = (op == OP_DECRYPT) ? blk[{j, 3'b000} +: 8] : pad[{j, 3'b000} +: 8];
      end
      S_PRIME0: raddr = {scratch, sched_pos(full, c)};
      S_PRIME1: raddr = {scratch, sched_pos(full, c + 7'd1)};
      S_ROUND: begin
        we    = 1'b1;
        waddr = {scratch, sched_pos(full, c + 7'd1)};
        wdata = rdata ^ sub;
        raddr = (c == last) ? {scratch, 3'd0} : {scratch, sched_pos(full, c + 7'd2)};
      end
      S_MIX: begin
        we    = 1'b1;
        waddr = {1'b0, j};
        wdata = rdata ^ pad[{j, 3'b000} +: 8];
        raddr = {1'b0, j + 3'd1};
      end
      S_READ: raddr = {scratch, j + 3'd1};
      S_IDLE, S_HOLD: ;
      default: ;
    endcase
  end

  // RAM: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    mem_q    <= mem[raddr];
    rd_fwd   <= we && (waddr == raddr);
    fwd_data <= wdata;
  end

  // control and architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      mac_key    <= '0;
      mac_padded <= 1'b0;
      vld        <= '0;
      rd_valid   <= 1'b0;
    end else begin
      rd_valid <= vld[raddr];
      if (we) begin
        vld[waddr] <= 1'b1;
      end
      // a new beat loads the output register as the old one leaves
      if (state == S_HOLD && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            priority if (op_in == OP_DECRYPT) begin
              state <= S_LOAD;
            end else if (op_in == OP_MAC_FIRST) begin
              mac_key <= key_build(key_bytes, key_tail, ten_byte_key);
              state   <= S_LOAD;
            end else begin
              state <= S_PRIME0;
            end
          end
        end
        S_LOAD: begin
          if (j == 3'd7) begin
            if (op == OP_MAC_FIRST) begin
              mac_padded <= pad_flag;
              state      <= S_IDLE;
            end else begin
              state <= S_PRIME0;
            end
          end
        end
        S_PRIME0: state <= S_PRIME1;
        S_PRIME1: state <= S_ROUND;
        S_ROUND: begin
          if (c == last) begin
            priority if (op == OP_MAC_NEXT) begin
              mac_key    <= key_rot(kcur);
              mac_padded <= pad_flag;
              state      <= S_MIX;
            end else if (op == OP_MAC_FINAL) begin
              mac_key <= kcur;
              state   <= S_READ;
            end else begin
              state <= S_READ;
            end
          end
        end
        S_MIX: if (j == 3'd7) state <= S_IDLE;
        S_READ: if (j == 3'd7) state <= S_HOLD;
        S_HOLD: begin
          if (!out_valid || out_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        op       <= op_in;
        blk      <= block;
        pad      <= pad_block(block, byte_count);
        pad_flag <= (byte_count < 4'd8);
        sig      <= expected_signature;
        scratch  <= (op_in == OP_DECRYPT);
        full     <= (op_in == OP_DECRYPT);
        j        <= '0;
        c        <= '0;
        ki       <= '0;
        priority if (op_in == OP_DECRYPT) begin
          last     <= LAST_FULL;
          work_key <= key_build(key_bytes, key_tail, ten_byte_key);
        end else if (op_in == OP_MAC_FINAL && mac_padded) begin
          last     <= LAST_PADDED;
          work_key <= mac_key;
        end else begin
          last     <= LAST_SHORT;
          work_key <= mac_key;
        end
      end
      S_LOAD: j <= j + 3'd1;
      S_PRIME1: cur <= rdata;
      S_ROUND: begin
        cur      <= wdata;
        work_key <= kcur;
        ki       <= (ki == KEY_LAST_IDX) ? 4'd0 : ki + 4'd1;
        c        <= c + 7'd1;
        j        <= '0;
      end
      S_MIX: j <= j + 3'd1;
      S_READ: begin
        rbuf[{j, 3'b000} +: 8] <= rdata;
        j <= j + 3'd1;
      end
      S_HOLD: begin
        if (!out_valid || out_ready) begin
          result_block <= rbuf;
          signature_ok <= (op == OP_MAC_FINAL) && (rbuf[39:0] == sig);
        end
      end
      S_PRIME0: ;
      default: ;
    endcase
  end

endmodule

[src/sbc_checker.sv]
// ----------------------------------------------------------------------------
// sbc_checker: port-level checks for sbox_byte_cipher_with_mac
// Watches handshakes and counts outstanding result-producing items.
// ----------------------------------------------------------------------------
module sbc_checker
  import sbc_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  operation,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] result_block,
  input logic        signature_ok
);

  logic [1:0] pend;
  logic       inc;
  logic       dec;

  // decrypt and mac final each owe exactly one result beat
  assign inc = in_valid && in_ready &&
               (op_t'(operation) == OP_DECRYPT || op_t'(operation) == OP_MAC_FINAL);
  assign dec = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else begin
      pend <= pend + 2'(inc) - 2'(dec);
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_block) && $stable(signature_ok))
    else $error("result beat changed while stalled");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("ready again right after accepting an item");

  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_owed: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pend != 2'd0)
    else $error("result beat with no item owing one");

endmodule

bind sbox_byte_cipher_with_mac sbc_checker u_sbc_checker (
  .clk                (clk),
  .rst                (rst),
  .in_valid           (in_valid),
  .in_ready           (in_ready),
  .operation          (operation),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .result_block       (result_block),
  .signature_ok       (signature_ok)
);
